FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in the same cycle as c
`define ASSERT_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: same-cycle implication");

// a in one cycle is followed by c in the next
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/mpq_pkg.sv
// package: constants, types and helpers of the priority ready queue
package mpq_pkg;

   localparam int NUM_LEVELS  = 16;
   localparam int LEVEL_DEPTH = 16;
   localparam int PID_BITS    = 16;

   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int IDX_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_W = LVL_W + IDX_W;

   localparam logic MODE_ENQUEUE  = 1'b0;
   localparam logic MODE_DISPATCH = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] pid;
      logic [3:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic        out_valid;
      logic [15:0] out_pid;
      logic [3:0]  out_priority;
      logic        overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_read;
   } dp_sts_type;

   // levels beyond the last one saturate to the top level
   function automatic logic [LVL_W-1:0] sat_level(input logic [3:0] p);
      logic [LVL_W-1:0] r;
      if (int'(p) >= NUM_LEVELS) begin
         r = LVL_W'(NUM_LEVELS - 1);
      end else begin
         r = LVL_W'(p);
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(LEVEL_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/multilevel_priority_ready_queue_unit.sv
// top level of the multilevel priority ready queue
// Usage:
//   A request item (req_data) is taken at a rising edge where start is high
//   and busy is low. Mode enqueue appends the pid to the fifo of its level,
//   or drops it and flags overflow when that fifo is full. Mode dispatch pops
//   the oldest pid of the highest non-empty level, or reports out_valid low
//   when every level is empty.
//   Each item gives exactly one result on rsp_data, shown for one cycle with
//   rsp_valid high; the receiver must take it then, there is no back-pressure.
//   An enqueue or an empty dispatch answers from the execute state; a
//   dispatch that finds a pid answers from a further response state, which
//   waits for the registered read of the entry store.
//   Busy drops in the cycle the result is shown, so a new item is taken only
//   once the previous one has answered, as set by the controller's state
//   sequence.
//   Reset (synchronous, active high) empties every level; the entry store is
//   not cleared, since only occupied slots are ever read.
`include "assert_macros.svh"

module multilevel_priority_ready_queue_unit
   import mpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   mpq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   mpq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)

endmodule

FILE: rtl/core/mpq_ctrl.sv
// controller state machine of the priority ready queue
`include "assert_macros.svh"

module mpq_ctrl
   import mpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            // only a dispatch that finds an item waits for the store read
            state_in = sts.need_read ? S_RESP : S_IDLE;
         end
         S_RESP: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_to_exec, clock, reset, start && !busy, state_ff == S_EXEC)
   `ASSERT_NEXT(a_resp_to_idle, clock, reset, state_ff == S_RESP, state_ff == S_IDLE)

endmodule

FILE: rtl/core/mpq_dpath.sv
// datapath of the priority ready queue: per-level fifo pointers and entry store
`include "assert_macros.svh"

module mpq_dpath
   import mpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output dp_sts_type  sts,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   req_type                req_ff;
   logic [IDX_W-1:0]       head_ff [NUM_LEVELS];
   logic [IDX_W-1:0]       head_in [NUM_LEVELS];
   logic [IDX_W-1:0]       tail_ff [NUM_LEVELS];
   logic [IDX_W-1:0]       tail_in [NUM_LEVELS];
   logic [CNT_W-1:0]       count_ff [NUM_LEVELS];
   logic [CNT_W-1:0]       count_in [NUM_LEVELS];
   logic [PID_BITS-1:0]    store [2**ADDR_W];
   logic [PID_BITS-1:0]    rd_data_ff;
   logic [LVL_W-1:0]       lvl_ff, lvl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [NUM_LEVELS-1:0]  occupied;
   logic                   any_occ;
   logic [LVL_W-1:0]       top_lvl;
   logic [LVL_W-1:0]       enq_lvl;
   logic                   full;
   logic                   is_dispatch;
   logic                   mem_we, mem_re;
   logic [ADDR_W-1:0]      waddr, raddr;

   // occupancy and highest non-empty level
   always_comb begin
      top_lvl = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         occupied[i] = (count_ff[i] != '0);
         if (occupied[i]) begin
            top_lvl = LVL_W'(i);
         end
      end
      any_occ = |occupied;
   end

   assign enq_lvl       = sat_level(req_ff.priority_req);
   assign full          = (count_ff[enq_lvl] == CNT_W'(LEVEL_DEPTH));
   assign is_dispatch   = (req_ff.mode == MODE_DISPATCH);
   assign sts.need_read = is_dispatch && any_occ;
   assign waddr         = {enq_lvl, tail_ff[enq_lvl]};
   assign raddr         = {top_lvl, head_ff[top_lvl]};

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      lvl_in       = lvl_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.execute) begin
         if (!is_dispatch) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.overflow = full;
            if (!full) begin
               mem_we            = 1'b1;
               tail_in[enq_lvl]  = next_idx(tail_ff[enq_lvl]);
               count_in[enq_lvl] = count_ff[enq_lvl] + 1'b1;
            end
         end else if (!any_occ) begin
            // empty queue: answer at once with nothing dispatched
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
         end else begin
            mem_re            = 1'b1;
            lvl_in            = top_lvl;
            head_in[top_lvl]  = next_idx(head_ff[top_lvl]);
            count_in[top_lvl] = count_ff[top_lvl] - 1'b1;
         end
      end else if (cmd.finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_valid    = 1'b1;
         rsp_in.out_pid      = 16'(rd_data_ff);
         rsp_in.out_priority = 4'(lvl_ff);
         rsp_in.overflow     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      lvl_ff <= lvl_in;
      rsp_ff <= rsp_in;
   end

   // entry store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[waddr] <= PID_BITS'(req_ff.pid);
      end
      if (mem_re) begin
         rd_data_ff <= store[raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_SAME(a_count_bound, clock, reset, cmd.execute,
                count_ff[enq_lvl] <= CNT_W'(LEVEL_DEPTH))
   `ASSERT_SAME(a_dispatch_no_ovf, clock, reset, rsp_valid_ff && rsp_ff.out_valid,
                !rsp_ff.overflow)

endmodule

FILE: tb/tb.sv
// testbench for the multilevel priority ready queue: directed and random items against a predictor
`timescale 1ns / 100ps

module tb;
   import mpq_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int MAX_GAP        = 12;
   localparam int TAIL_CYCLES    = 8;
   localparam logic [15:0] PID_MASK = 16'((64'd1 << PID_BITS) - 1);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   multilevel_priority_ready_queue_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b1;
      #CLK_HALF;
      clock = 1'b0;
      #CLK_HALF;
   end

   // shadow copy of the per-level fifos
   logic [15:0] lvl_slots [NUM_LEVELS][LEVEL_DEPTH];
   int          lvl_head  [NUM_LEVELS];
   int          lvl_tail  [NUM_LEVELS];
   int          lvl_fill  [NUM_LEVELS];

   rsp_type pending_rsps[$];
   int      mismatches;
   int      idle_pct;
   int      stall_cycles;
   int      n_enqueue, n_dropped, n_dispatch, n_empty;

   // what the queue answers to one item, updating the shadow state
   function automatic rsp_type predict_ready_queue(req_type it);
      rsp_type r;
      int      lvl;
      int      top;
      r   = '0;
      top = -1;
      if (it.mode == MODE_ENQUEUE) begin
         n_enqueue++;
         lvl = (int'(it.priority_req) >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(it.priority_req);
         if (lvl_fill[lvl] >= LEVEL_DEPTH) begin
            r.overflow = 1'b1;
            n_dropped++;
         end else begin
            lvl_slots[lvl][lvl_tail[lvl]] = it.pid & PID_MASK;
            lvl_tail[lvl] = (lvl_tail[lvl] + 1) % LEVEL_DEPTH;
            lvl_fill[lvl]++;
         end
      end else begin
         n_dispatch++;
         for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (top < 0 && lvl_fill[l] != 0) top = l;
         end
         if (top < 0) begin
            n_empty++;
         end else begin
            r.out_valid    = 1'b1;
            r.out_pid      = lvl_slots[top][lvl_head[top]];
            r.out_priority = 4'(top);
            lvl_head[top]  = (lvl_head[top] + 1) % LEVEL_DEPTH;
            lvl_fill[top]--;
         end
      end
      return r;
   endfunction

   // present one item, hold it until taken, record what it should produce
   task automatic send_item(req_type it);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      pending_rsps.push_back(predict_ready_queue(it));
   endtask

   task automatic send_op(logic mode, logic [15:0] pid, logic [3:0] prio);
      req_type it;
      it.mode         = mode;
      it.pid          = pid;
      it.priority_req = prio;
      send_item(it);
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      start <= 1'b0;
      wait (pending_rsps.size() == 0);
   endtask

   task automatic flag_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            $display("%0t: result with nothing expected: expected none, actual %h",
                     $time, rsp_data);
            mismatches++;
         end else begin
            want = pending_rsps.pop_front();
            flag_field("out_valid", want.out_valid, rsp_data.out_valid);
            flag_field("out_pid", want.out_pid, rsp_data.out_pid);
            flag_field("out_priority", want.out_priority, rsp_data.out_priority);
            flag_field("overflow", want.overflow, rsp_data.overflow);
         end
      end
   end

   // watchdog on cycles in which no handshake happens
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // empty dispatch, field extremes, level order
   task automatic test_directed();
      send_op(MODE_DISPATCH, 16'hFFFF, 4'hF);
      send_op(MODE_ENQUEUE, 16'hFFFF, 4'h0);
      send_op(MODE_ENQUEUE, 16'h0000, 4'hF);
      send_op(MODE_ENQUEUE, 16'hA5A5, 4'h7);
      send_op(MODE_ENQUEUE, 16'h5A5A, 4'h7);
      repeat (4) send_op(MODE_DISPATCH, 16'h0000, 4'h0);
      send_op(MODE_DISPATCH, 16'h1234, 4'h8);
   endtask

   // fill one level, then an item that finds it full
   task automatic test_full_level();
      for (int i = 0; i <= LEVEL_DEPTH; i++) send_op(MODE_ENQUEUE, 16'($urandom), 4'h9);
      pause_until_drained();
   endtask

   // bursts aimed at a few levels, alternating fill and drain, with some noise
   task automatic test_random(int n_items, int pct);
      int      sent;
      int      burst;
      int      lo, hi, len, enq_bias;
      req_type it;
      idle_pct = pct;
      sent     = 0;
      burst    = 0;
      while (sent < n_items) begin
         lo       = $urandom_range(15);
         hi       = lo + $urandom_range(2);
         if (hi > 15) hi = 15;
         len      = $urandom_range(8, 40);
         enq_bias = (burst % 2 == 0) ? 85 : 25;
         for (int i = 0; i < len && sent < n_items; i++) begin
            it.mode = ($urandom_range(99) < enq_bias) ? MODE_ENQUEUE : MODE_DISPATCH;
            it.pid  = 16'($urandom);
            if ($urandom_range(9) == 0) it.priority_req = 4'($urandom_range(15));
            else it.priority_req = 4'($urandom_range(hi, lo));
            send_item(it);
            sent++;
         end
         if ($urandom_range(2) == 0) pause_until_drained();
         burst++;
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      mismatches   = 0;
      idle_pct     = 0;
      stall_cycles = 0;
      n_enqueue    = 0;
      n_dropped    = 0;
      n_dispatch   = 0;
      n_empty      = 0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         lvl_head[l] = 0;
         lvl_tail[l] = 0;
         lvl_fill[l] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_level();
      test_random(95, 0);
      test_random(95, 46);
      test_random(95, 0);
      test_random(95, 37);

      pause_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d enqueues (%0d dropped on a full level) and %0d dispatches",
               n_enqueue, n_dropped, n_dispatch);
      $display("%0d dispatches found the queue empty", n_empty);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: multilevel_priority_ready_queue_unit.f
+incdir+rtl/core
rtl/core/mpq_pkg.sv
rtl/core/mpq_ctrl.sv
rtl/core/mpq_dpath.sv
rtl/core/multilevel_priority_ready_queue_unit.sv
tb/tb.sv
